// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property holds on every clock edge out of reset
`define OAT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("oat assertion failed");
// same-cycle implication
`define OAT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("oat implication failed");
// next-cycle implication
`define OAT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("oat next-cycle implication failed");
`else
`define OAT_ASSERT(lbl, clk, rstn, prop)
`define OAT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define OAT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/oat_pkg.sv =====
// ---------------------------------------------------------------------------
// oat_pkg
// shared operation codes, status codes, control state encoding and cell command type
// ---------------------------------------------------------------------------
package oat_pkg;

    typedef enum logic [2:0] {
        K_CLEAR  = 3'd0,
        K_APPEND = 3'd1,
        K_INSERT = 3'd2,
        K_DELETE = 3'd3,
        K_SEARCH = 3'd4,
        K_READ   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BADPOS  = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    // broadcast to every cell of the row
    typedef struct packed {
        logic ins;    // open a slot at the position and load the key
        logic del;    // close the slot at the position
        logic srch;   // flag cells holding the key
        logic rd;     // flag the cell at the position
    } t_cell_cmd;

endpackage

// ===== rtl/oat_cell.sv =====
// ---------------------------------------------------------------------------
// oat_cell
// one entry of the list: shifts with its neighbors and matches locally
// ---------------------------------------------------------------------------
module oat_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int XW  = 7
) (
    input  logic                  i_clk,
    input  oat_pkg::t_cell_cmd    i_cmd,
    input  logic [XW-1:0]         i_pos,
    input  logic [CW-1:0]         i_cnt,
    input  logic signed [31:0]    i_key,
    input  logic signed [31:0]    i_left,
    input  logic signed [31:0]    i_right,
    output logic signed [31:0]    o_data,
    output logic                  o_hit
);
    import oat_pkg::*;

    localparam logic [XW-1:0] MY_POS = XW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;
    logic               w_live;

    assign w_live = MY_CNT < i_cnt;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_POS == i_pos) begin
                n_data = i_key;
            end else if (MY_POS > i_pos) begin
                n_data = i_left;
            end
        end else if (i_cmd.del) begin
            if (MY_POS >= i_pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_hit  = w_live && ((i_cmd.srch && (r_data == i_key)) ||
                               (i_cmd.rd && (MY_POS == i_pos)));

endmodule

// ===== rtl/oat_reduce.sv =====
// ---------------------------------------------------------------------------
// oat_reduce
// folds cell flags down to the lowest flagged index, one level per cycle while stepped
// ---------------------------------------------------------------------------
module oat_reduce #(
    parameter int LEAVES = 64,
    parameter int IW     = 6
) (
    input  logic                  i_clk,
    input  logic                  i_load,
    input  logic                  i_step,
    input  logic [LEAVES-1:0]     i_hit,
    input  logic signed [31:0]    i_val [LEAVES],
    output logic                  o_hit,
    output logic [IW-1:0]         o_idx,
    output logic signed [31:0]    o_val
);
    import oat_pkg::*;

    logic               r_hit [LEAVES];
    logic [IW-1:0]      r_idx [LEAVES];
    logic signed [31:0] r_val [LEAVES];
    logic               n_hit [LEAVES];
    logic [IW-1:0]      n_idx [LEAVES];
    logic signed [31:0] n_val [LEAVES];

    always_comb begin
        for (int k = 0; k < LEAVES; k++) begin
            n_hit[k] = r_hit[k];
            n_idx[k] = r_idx[k];
            n_val[k] = r_val[k];
            if (i_load) begin
                n_hit[k] = i_hit[k];
                n_idx[k] = IW'(k);
                n_val[k] = i_val[k];
            end else if (i_step) begin
                if (k < LEAVES / 2) begin
                    // lower node of the pair wins, keeping first-match order
                    if (r_hit[2*k]) begin
                        n_hit[k] = 1'b1;
                        n_idx[k] = r_idx[2*k];
                        n_val[k] = r_val[2*k];
                    end else begin
                        n_hit[k] = r_hit[2*k+1];
                        n_idx[k] = r_idx[2*k+1];
                        n_val[k] = r_val[2*k+1];
                    end
                end else begin
                    n_hit[k] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LEAVES; k++) begin
            r_hit[k] <= n_hit[k];
            r_idx[k] <= n_idx[k];
            r_val[k] <= n_val[k];
        end
    end

    assign o_hit = r_hit[0];
    assign o_idx = r_idx[0];
    assign o_val = r_val[0];

endmodule

// ===== rtl/ordered_array_table_unit.sv =====
// ---------------------------------------------------------------------------
// ordered_array_table_unit
// positional list of signed 32-bit entries held in a row of shifting cells
// ---------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) takes one word per operation:
//   i_kind, i_position, i_value. output channel (o_out_valid / i_out_ready)
//   returns exactly one word per operation: status, found index, read value
//   and the entry count after the operation.
// operation flow
//   clear, append, insert, delete and unused kinds finish at the accept edge:
//   the result word is valid the next cycle, one word per cycle while i_out_ready is high.
//   search and read flag matching cells, then fold the flags through a
//   halving tree one level per cycle and register the result word when the
//   fold reaches the root. no new word is taken while the fold runs; the
//   next word can be accepted in the same cycle the result is drained.
// reset
//   synchronous active-low reset empties the list and the output register;
//   no clearing pass, entries are only ever read below the count.
// stall
//   the output register holds its word while i_out_ready is low, and a new
//   word is only accepted when that register is free or being drained.
// ---------------------------------------------------------------------------
module ordered_array_table_unit #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_kind,
    input  logic [5:0]         i_position,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [5:0]         o_found_index,
    output logic signed [31:0] o_read_value,
    output logic [6:0]         o_entry_count
);
    import oat_pkg::*;

    `include "assert_macros.svh"

    // count width holds DEPTH itself
    localparam int CW     = $clog2(DEPTH + 1);
    // position compare width covers both the count and the 6-bit port
    localparam int XW     = (CW > 6) ? CW : 6;
    localparam int IW     = $clog2(DEPTH);
    localparam int LEAVES = 1 << IW;
    localparam int LEVELS = IW;
    localparam int LW     = $clog2(LEVELS + 1);
    localparam int OW     = (CW > 7) ? CW : 7;
    localparam int FW     = (IW > 6) ? IW : 6;

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [LW-1:0]   r_lvl, n_lvl;
    logic            r_out_valid, n_out_valid;
    logic            r_is_search, n_is_search;

    // output word
    t_status            r_status, n_status;
    logic [5:0]         r_found_index, n_found_index;
    logic signed [31:0] r_read_value, n_read_value;
    logic [6:0]         r_entry_count, n_entry_count;

    // handshake and decode
    logic            w_acc;
    logic            w_full;
    logic [XW-1:0]   w_pos_x;
    logic [XW-1:0]   w_cnt_x;
    logic [XW-1:0]   w_cell_pos;
    t_cell_cmd       w_cmd;
    logic            w_direct;
    logic            w_scan;
    t_status         w_dir_status;
    logic            w_finish;
    logic [OW-1:0]   w_cnt_wide;
    logic [OW-1:0]   w_cur_wide;
    logic [FW-1:0]   w_idx_wide;

    // cell row and fold tree
    logic signed [31:0] w_data [DEPTH];
    logic [DEPTH-1:0]   w_cell_hit;
    logic [LEAVES-1:0]  w_leaf_hit;
    logic signed [31:0] w_leaf_val [LEAVES];
    logic               w_red_hit;
    logic [IW-1:0]      w_red_idx;
    logic signed [31:0] w_red_val;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_full     = r_count == CW'(DEPTH);
    assign w_pos_x    = XW'(i_position);
    assign w_cnt_x    = XW'(r_count);
    assign w_finish   = (r_state == S_SCAN) && (r_lvl == '0);

    // operation decode: direct ops finish at the accept edge
    always_comb begin
        w_cmd        = '0;
        w_cell_pos   = w_pos_x;
        w_direct     = 1'b1;
        w_scan       = 1'b0;
        w_dir_status = ST_OK;
        n_count      = r_count;
        case (i_kind)
            K_CLEAR: begin
                n_count = '0;
            end
            K_APPEND: begin
                w_cell_pos = w_cnt_x;
                if (w_full) begin
                    w_dir_status = ST_FULL;
                end else begin
                    w_cmd.ins = w_acc;
                    n_count   = r_count + 1'b1;
                end
            end
            K_INSERT: begin
                // bad position is checked before the full list
                if (w_pos_x > w_cnt_x) begin
                    w_dir_status = ST_BADPOS;
                end else if (w_full) begin
                    w_dir_status = ST_FULL;
                end else begin
                    w_cmd.ins = w_acc;
                    n_count   = r_count + 1'b1;
                end
            end
            K_DELETE: begin
                if (w_pos_x >= w_cnt_x) begin
                    w_dir_status = ST_BADPOS;
                end else begin
                    w_cmd.del = w_acc;
                    n_count   = r_count - 1'b1;
                end
            end
            K_SEARCH: begin
                w_cmd.srch = 1'b1;
                w_direct   = 1'b0;
                w_scan     = 1'b1;
            end
            K_READ: begin
                w_cmd.rd = 1'b1;
                w_direct = 1'b0;
                w_scan   = 1'b1;
            end
            default: begin
                // unused kinds leave the list and its count as they are
            end
        endcase
    end

    // row of cells, each fed by its lower and upper neighbor (end cells by themselves)
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int LFT = (g == 0) ? 0 : g - 1;
        localparam int RGT = (g == DEPTH - 1) ? g : g + 1;
        oat_cell #(
            .IDX (g),
            .CW  (CW),
            .XW  (XW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_pos   (w_cell_pos),
            .i_cnt   (r_count),
            .i_key   (i_value),
            .i_left  (w_data[LFT]),
            .i_right (w_data[RGT]),
            .o_data  (w_data[g]),
            .o_hit   (w_cell_hit[g])
        );
    end

    // pad the tree up to a power of two with empty leaves
    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k < DEPTH) begin : g_real
            assign w_leaf_hit[k] = w_cell_hit[k];
            assign w_leaf_val[k] = w_data[k];
        end else begin : g_pad
            assign w_leaf_hit[k] = 1'b0;
            assign w_leaf_val[k] = '0;
        end
    end

    oat_reduce #(
        .LEAVES (LEAVES),
        .IW     (IW)
    ) u_reduce (
        .i_clk  (i_clk),
        .i_load (w_acc && w_scan),
        .i_step ((r_state == S_SCAN) && (r_lvl != '0)),
        .i_hit  (w_leaf_hit),
        .i_val  (w_leaf_val),
        .o_hit  (w_red_hit),
        .o_idx  (w_red_idx),
        .o_val  (w_red_val)
    );

    assign w_cnt_wide = OW'(n_count);
    assign w_cur_wide = OW'(r_count);
    assign w_idx_wide = FW'(w_red_idx);

    // sequencing and output register
    always_comb begin
        n_state       = r_state;
        n_lvl         = r_lvl;
        n_is_search   = r_is_search;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_status      = r_status;
        n_found_index = r_found_index;
        n_read_value  = r_read_value;
        n_entry_count = r_entry_count;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (w_direct) begin
                        n_out_valid   = 1'b1;
                        n_status      = w_dir_status;
                        n_found_index = '0;
                        n_read_value  = '0;
                        n_entry_count = w_cnt_wide[6:0];
                    end else begin
                        n_state     = S_SCAN;
                        n_lvl       = LW'(LEVELS);
                        n_is_search = (i_kind == K_SEARCH);
                    end
                end
            end
            S_SCAN: begin
                if (w_finish) begin
                    n_state       = S_IDLE;
                    n_out_valid   = 1'b1;
                    n_entry_count = w_cur_wide[6:0];
                    n_found_index = '0;
                    n_read_value  = '0;
                    if (r_is_search) begin
                        n_status = w_red_hit ? ST_OK : ST_MISSING;
                        if (w_red_hit) begin
                            n_found_index = w_idx_wide[5:0];
                        end
                    end else begin
                        n_status = w_red_hit ? ST_OK : ST_BADPOS;
                        if (w_red_hit) begin
                            n_read_value = w_red_val;
                        end
                    end
                end else begin
                    n_lvl = r_lvl - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
            r_is_search <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= (w_acc && w_direct) ? n_count : r_count;
            r_lvl       <= n_lvl;
            r_out_valid <= n_out_valid;
            r_is_search <= n_is_search;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status      <= n_status;
        r_found_index <= n_found_index;
        r_read_value  <= n_read_value;
        r_entry_count <= n_entry_count;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_found_index;
    assign o_read_value  = r_read_value;
    assign o_entry_count = r_entry_count;

    // checks
    `OAT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `OAT_ASSERT_IMP(a_slot_free, i_clk, i_rst_n, w_acc, (!r_out_valid || i_out_ready))
    `OAT_ASSERT_NXT(a_ins_grows, i_clk, i_rst_n, w_acc && w_cmd.ins, r_count == $past(r_count) + 1'b1)
    `OAT_ASSERT_IMP(a_scan_blocks, i_clk, i_rst_n, r_state == S_SCAN, !o_in_ready && !w_cmd.ins && !w_cmd.del)

endmodule
